[src/langevin_ring_lattice_step_defines.svh]
// Assertion macros shared by the RTL of the lattice step.
`ifndef LANGEVIN_RING_LATTICE_STEP_DEFINES_SVH
`define LANGEVIN_RING_LATTICE_STEP_DEFINES_SVH

`ifndef SYNTH
`define LRLS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lattice step assertion failed");
`define LRLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lattice step assertion failed");
`else
`define LRLS_ASSERT(lbl, prop)
`define LRLS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[src/lrls_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lrls_pkg;

  localparam int SITES_DEF = 64;

  localparam int SITE_OUT_W = 6;
  localparam int HEIGHT_W = 32;
  localparam int STEP_W = 25;
  localparam int NOISE_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SHEAR_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_FORCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_RATIO = 2'd2;

  localparam logic [31:0] TEMP_RATIO_RESET = 32'd65536;
  localparam logic [31:0] TC_TWICE = 32'd297426;
  localparam logic [STEP_W-1:0] DT_FLOOR = 25'd42950;
  localparam logic [STEP_W-1:0] DT_CEIL = 25'd21474837;
  localparam logic signed [53:0] DEN_BASE = 54'sd13107200;

  localparam logic [31:0] RAMP_STEP = 32'd6553;
  localparam logic [3:0] RAMP_REM_STEP = 4'd6;
  localparam logic [3:0] RAMP_REM_INIT = 4'd5;

endpackage

`default_nettype wire

[src/langevin_ring_lattice_step.sv]
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    in_noise_sample
// out      output     out_valid / out_stall  out_site_index, out_new_height,
//                                            out_step_size, out_last_of_sweep
// cfg      input      cfg_we                 cfg_index, cfg_wdata
// After reset a clearing pass loads the ramp into the height memory; no word is taken then.
// A word passes through three bit-serial multiplies; each ends when no set bit is left
// in its multiplier (up to 32 bits). A word at site 0 first adds a scan over the height
// memory, a multiply, a divide (skipped when the denominator is not positive), two
// multiplies and a square root.
// A finished word waits in the output register; only its write-back stalls on it.
`timescale 1ns / 1ps
`default_nettype none
`include "langevin_ring_lattice_step_defines.svh"

module langevin_ring_lattice_step
  import lrls_pkg::*;
#(
  parameter int SITES = SITES_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire  signed [NOISE_W-1:0]   in_noise_sample,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic [SITE_OUT_W-1:0]       out_site_index,
  output logic signed [HEIGHT_W-1:0]  out_new_height,
  output logic [STEP_W-1:0]           out_step_size,
  output logic                        out_last_of_sweep,
  input  wire                         cfg_we,
  input  wire  [CFG_IDX_W-1:0]        cfg_index,
  input  wire  [CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int AW = $clog2(SITES);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN, ST_WRAP, ST_GMUL, ST_DCALC, ST_DIV, ST_DTFIX,
    ST_PSET, ST_PMUL, ST_RMUL, ST_SQRT, ST_RD0, ST_RD1, ST_RD2, ST_RD3,
    ST_LAP, ST_M1, ST_M2, ST_M3, ST_WB
  } state_t;

  state_t state_r;

  logic signed [31:0] shear_r, force_r;
  logic [31:0]        ttc_r;

  logic [AW-1:0]      pos_r;
  logic [STEP_W-1:0]  dt_r;
  logic [31:0]        nscale_r;
  logic signed [31:0] prev_r, first_r, h_r, right_r, left_r;
  logic signed [NOISE_W-1:0] noise_r;

  logic [AW-1:0]      clr_r;
  logic [31:0]        ramp_q_r;
  logic [3:0]         ramp_rem_r;

  logic [AW:0]        sc_r;
  logic signed [31:0] hm1_r, hm2_r, h0_r, h1_r;
  logic [31:0]        maxd_r;

  logic [63:0]        mul_a_r, mul_p_r;
  logic [31:0]        mul_b_r;

  logic signed [53:0] den_r;
  logic [53:0]        num_r, quot_r;
  logic [54:0]        rem_r;
  logic [5:0]         dcnt_r;

  logic [63:0]        sx_r, sr_r, sbit_r;

  logic               lap_neg_r;
  logic signed [39:0] acc_r;

  logic               out_valid_r;
  logic [SITE_OUT_W-1:0] out_site_r;
  logic signed [31:0] out_height_r;
  logic [STEP_W-1:0]  out_step_r;
  logic               out_last_r;

  logic [31:0]        mem [SITES];
  logic signed [31:0] rd_q;
  logic               mem_we;
  logic [AW-1:0]      mem_wa, mem_ra;
  logic [31:0]        mem_wd;

  function automatic logic [31:0] absdiff(input logic signed [31:0] a,
                                          input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    absdiff = d[32] ? 32'(-d) : d[31:0];
  endfunction

  logic               last;
  logic               out_blocked;
  logic [31:0]        scan_d, wrap_a, wrap_b, max_wrap;
  logic [31:0]        gmag;
  logic [53:0]        gm10;
  logic signed [53:0] den_calc;
  logic [54:0]        rem_sh;
  logic [63:0]        sq_try;
  logic signed [34:0] lap;
  logic [34:0]        lap_mag;
  logic [31:0]        t1, t3;
  logic [35:0]        t2;
  logic signed [39:0] t3s;
  logic signed [31:0] sat;

  assign last = (pos_r == AW'(SITES - 1));
  assign out_blocked = out_valid_r && out_stall;
  assign in_stall = (state_r != ST_IDLE);

  assign scan_d = absdiff(rd_q, hm2_r);
  assign wrap_a = absdiff(h1_r, hm1_r);
  assign wrap_b = absdiff(h0_r, hm2_r);
  always_comb begin
    max_wrap = maxd_r;
    if (wrap_a > max_wrap) begin
      max_wrap = wrap_a;
    end
    if (wrap_b > max_wrap) begin
      max_wrap = wrap_b;
    end
  end

  assign gmag = shear_r[31] ? 32'(-shear_r) : shear_r;
  assign gm10 = {3'b0, mul_p_r[63:16], 3'b0} + {5'b0, mul_p_r[63:16], 1'b0};
  assign den_calc = shear_r[31] ? (DEN_BASE - $signed(gm10)) : (DEN_BASE + $signed(gm10));
  assign rem_sh = {rem_r[53:0], num_r[53]};
  assign sq_try = sr_r + sbit_r;

  assign lap = {{3{right_r[31]}}, right_r} - {{2{h_r[31]}}, h_r, 1'b0}
             + {{3{left_r[31]}}, left_r};
  assign lap_mag = lap[34] ? 35'(-lap) : lap;

  assign t1 = 32'((mul_p_r + 64'h8000_0000) >> 32);
  assign t2 = 36'((mul_p_r + 64'h800) >> 12);
  assign t3 = 32'((mul_p_r + 64'h8000_0000) >> 32);
  assign t3s = force_r[31] ? -$signed({8'b0, t3}) : $signed({8'b0, t3});

  always_comb begin
    if (acc_r > 40'sd2147483647) begin
      sat = 32'sh7FFF_FFFF;
    end else if (acc_r < -40'sd2147483648) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = acc_r[31:0];
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = pos_r;
    mem_wd = sat;
    mem_ra = pos_r;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = ramp_q_r;
      end
      ST_SCAN: begin
        mem_ra = (sc_r < (AW+1)'(SITES)) ? sc_r[AW-1:0] : '0;
      end
      ST_RD1: begin
        mem_ra = last ? '0 : pos_r + AW'(1);
      end
      ST_RD2: begin
        mem_ra = AW'(SITES - 1);
      end
      ST_WB: begin
        mem_we = !out_blocked;
      end
      default: begin
        mem_ra = pos_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      ramp_q_r    <= '0;
      ramp_rem_r  <= RAMP_REM_INIT;
      pos_r       <= '0;
      dt_r        <= '0;
      nscale_r    <= '0;
      prev_r      <= '0;
      first_r     <= '0;
      shear_r     <= '0;
      force_r     <= '0;
      ttc_r       <= TEMP_RATIO_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SHEAR_GAIN: shear_r <= cfg_wdata;
          CFG_STEP_FORCE: force_r <= cfg_wdata;
          CFG_TEMP_RATIO: ttc_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall && state_r != ST_WB) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          if (ramp_rem_r + RAMP_REM_STEP >= 4'd10) begin
            ramp_rem_r <= ramp_rem_r + RAMP_REM_STEP - 4'd10;
            ramp_q_r   <= ramp_q_r + RAMP_STEP + 32'd1;
          end else begin
            ramp_rem_r <= ramp_rem_r + RAMP_REM_STEP;
            ramp_q_r   <= ramp_q_r + RAMP_STEP;
          end
          if (clr_r == AW'(SITES - 1)) begin
            state_r <= ST_IDLE;
          end else begin
            clr_r <= clr_r + AW'(1);
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            noise_r <= in_noise_sample;
            maxd_r  <= '0;
            sc_r    <= '0;
            state_r <= (pos_r == '0) ? ST_SCAN : ST_RD0;
          end
        end
        ST_SCAN: begin
          if (sc_r != '0) begin
            if (sc_r == (AW+1)'(1)) begin
              h0_r <= rd_q;
            end else if (sc_r == (AW+1)'(2)) begin
              h1_r <= rd_q;
            end else if (scan_d > maxd_r) begin
              maxd_r <= scan_d;
            end
            hm2_r <= hm1_r;
            hm1_r <= rd_q;
          end
          if (sc_r == (AW+1)'(SITES)) begin
            state_r <= ST_WRAP;
          end else begin
            sc_r <= sc_r + (AW+1)'(1);
          end
        end
        ST_WRAP: begin
          mul_a_r <= {32'b0, max_wrap};
          mul_b_r <= gmag;
          mul_p_r <= '0;
          state_r <= ST_GMUL;
        end
        ST_DCALC: begin
          if (den_r < 0) begin
            dt_r    <= DT_FLOOR;
            state_r <= ST_PSET;
          end else if (den_r == '0) begin
            dt_r    <= DT_CEIL;
            state_r <= ST_PSET;
          end else begin
            num_r   <= (54'd1 << 48) + {1'b0, den_r[53:1]};
            rem_r   <= '0;
            quot_r  <= '0;
            dcnt_r  <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (rem_sh >= {1'b0, den_r}) begin
            rem_r  <= rem_sh - {1'b0, den_r};
            quot_r <= {quot_r[52:0], 1'b1};
          end else begin
            rem_r  <= rem_sh;
            quot_r <= {quot_r[52:0], 1'b0};
          end
          num_r  <= num_r << 1;
          dcnt_r <= dcnt_r + 6'd1;
          if (dcnt_r == 6'd53) begin
            state_r <= ST_DTFIX;
          end
        end
        ST_DTFIX: begin
          if (quot_r < 54'(DT_FLOOR)) begin
            dt_r <= DT_FLOOR;
          end else if (quot_r > 54'(DT_CEIL)) begin
            dt_r <= DT_CEIL;
          end else begin
            dt_r <= quot_r[STEP_W-1:0];
          end
          state_r <= ST_PSET;
        end
        ST_PSET: begin
          mul_a_r <= 64'(dt_r);
          mul_b_r <= ttc_r;
          mul_p_r <= '0;
          state_r <= ST_PMUL;
        end
        ST_SQRT: begin
          if (sbit_r == '0) begin
            nscale_r <= sr_r[31:0];
            state_r  <= ST_RD0;
          end else begin
            if (sx_r >= sq_try) begin
              sx_r <= sx_r - sq_try;
              sr_r <= (sr_r >> 1) + sbit_r;
            end else begin
              sr_r <= sr_r >> 1;
            end
            sbit_r <= sbit_r >> 2;
          end
        end
        ST_RD0: begin
          state_r <= ST_RD1;
        end
        ST_RD1: begin
          h_r <= rd_q;
          if (pos_r == '0) begin
            first_r <= rd_q;
          end
          state_r <= ST_RD2;
        end
        ST_RD2: begin
          right_r <= last ? first_r : rd_q;
          state_r <= ST_RD3;
        end
        ST_RD3: begin
          left_r  <= (pos_r == '0) ? rd_q : prev_r;
          state_r <= ST_LAP;
        end
        ST_LAP: begin
          lap_neg_r <= lap[34];
          mul_a_r   <= 64'(lap_mag);
          mul_b_r   <= {4'b0, dt_r, 3'b0} + {6'b0, dt_r, 1'b0};
          mul_p_r   <= '0;
          acc_r     <= 40'(h_r);
          state_r   <= ST_M1;
        end
        ST_WB: begin
          if (!out_blocked) begin
            out_valid_r  <= 1'b1;
            out_site_r   <= SITE_OUT_W'(pos_r);
            out_height_r <= sat;
            out_step_r   <= dt_r;
            out_last_r   <= last;
            prev_r       <= h_r;
            pos_r        <= last ? '0 : pos_r + AW'(1);
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          if (mul_b_r != '0) begin
            if (mul_b_r[0]) begin
              mul_p_r <= mul_p_r + mul_a_r;
            end
            mul_a_r <= mul_a_r << 1;
            mul_b_r <= mul_b_r >> 1;
          end else begin
            case (state_r)
              ST_GMUL: begin
                den_r   <= den_calc;
                state_r <= ST_DCALC;
              end
              ST_PMUL: begin
                mul_a_r <= {16'b0, mul_p_r[63:16]};
                mul_b_r <= TC_TWICE;
                mul_p_r <= '0;
                state_r <= ST_RMUL;
              end
              ST_RMUL: begin
                sx_r    <= {16'b0, mul_p_r[63:16]};
                sr_r    <= '0;
                sbit_r  <= 64'd1 << 62;
                state_r <= ST_SQRT;
              end
              ST_M1: begin
                acc_r   <= lap_neg_r ? acc_r - 40'(t1) : acc_r + 40'(t1);
                mul_a_r <= {48'b0, (noise_r[15] ? 16'(-noise_r) : noise_r)};
                mul_b_r <= nscale_r;
                mul_p_r <= '0;
                state_r <= ST_M2;
              end
              ST_M2: begin
                acc_r   <= noise_r[15] ? acc_r - 40'(t2) : acc_r + 40'(t2);
                mul_a_r <= {32'b0, (force_r[31] ? 32'(-force_r) : force_r)};
                mul_b_r <= 32'(dt_r);
                mul_p_r <= '0;
                state_r <= ST_M3;
              end
              ST_M3: begin
                if (h_r > 0) begin
                  acc_r <= acc_r - t3s;
                end else if (h_r < 0) begin
                  acc_r <= acc_r + t3s;
                end
                state_r <= ST_WB;
              end
              default: begin
                state_r <= ST_IDLE;
              end
            endcase
          end
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_site_index    = out_site_r;
  assign out_new_height    = out_height_r;
  assign out_step_size     = out_step_r;
  assign out_last_of_sweep = out_last_r;

  `LRLS_ASSERT(a_clear_stalls, (state_r == ST_CLEAR) |-> in_stall)
  `LRLS_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_r != ST_IDLE)
  `LRLS_ASSERT_NEXT(a_wb_delivers, state_r == ST_WB && !out_blocked, out_valid_r)
  `LRLS_ASSERT(a_step_range,
    out_valid_r |-> (out_step_r >= DT_FLOOR && out_step_r <= DT_CEIL))

endmodule

`default_nettype wire

[tb/lrls_checker.sv]
`timescale 1ns / 1ps

module lrls_checker
  import lrls_pkg::*;
(
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  input  wire                        in_stall,
  input  wire signed [NOISE_W-1:0]   in_noise_sample,
  input  wire                        out_valid,
  input  wire                        out_stall,
  input  wire [SITE_OUT_W-1:0]       out_site_index,
  input  wire signed [HEIGHT_W-1:0]  out_new_height,
  input  wire [STEP_W-1:0]           out_step_size,
  input  wire                        out_last_of_sweep,
  input  wire                        cfg_we,
  input  wire [CFG_IDX_W-1:0]        cfg_index,
  input  wire [CFG_DATA_W-1:0]       cfg_wdata,
  output int                         errors,
  output int                         pending
);

  localparam int NSITES = SITES_DEF;

  typedef struct packed {
    logic [SITE_OUT_W-1:0]      site;
    logic signed [HEIGHT_W-1:0] height;
    logic [STEP_W-1:0]          dt;
    logic                       last;
  } site_word_t;

  site_word_t updates_due[$];

  logic signed [31:0] lattice [NSITES];
  int                 cursor;
  logic [31:0]        dt_sweep;
  logic [31:0]        noise_gain;
  logic signed [31:0] prev_old;
  logic signed [31:0] first_old;
  logic signed [31:0] gain_g;
  logic signed [31:0] force_h;
  logic [31:0]        ttc;

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint rounded_scale(longint v, longint unsigned f, int s);
    longint unsigned m;
    m = mag(v) * f;
    m = (m + (64'd1 << (s - 1))) >> s;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [31:0] root_floor(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  task automatic open_sweep();
    longint unsigned widest;
    longint unsigned gm;
    longint unsigned q;
    longint unsigned p;
    longint unsigned rad;
    longint          den;
    longint          a;
    longint          b;
    widest = 0;
    for (int i = 0; i < NSITES; i++) begin
      a = lattice[(i + 1) % NSITES];
      b = lattice[(i + NSITES - 1) % NSITES];
      if (mag(a - b) > widest) widest = mag(a - b);
    end
    gm = ((mag(longint'(gain_g)) * widest) >> 16) * 10;
    den = (gain_g < 0) ? 64'sd13107200 - longint'(gm) : 64'sd13107200 + longint'(gm);
    if (den < 0) begin
      dt_sweep = 32'(DT_FLOOR);
    end else if (den == 0) begin
      dt_sweep = 32'(DT_CEIL);
    end else begin
      q = ((64'd1 << 48) + longint'(den) / 2) / longint'(den);
      if (q < 64'(DT_FLOOR)) q = 64'(DT_FLOOR);
      if (q > 64'(DT_CEIL)) q = 64'(DT_CEIL);
      dt_sweep = q[31:0];
    end
    p = (64'(dt_sweep) * 64'(ttc)) >> 16;
    rad = (p * 64'd148713 * 2) >> 16;
    noise_gain = root_floor(rad);
  endtask

  task automatic predict_site(logic signed [NOISE_W-1:0] noise);
    longint     h;
    longint     left;
    longint     right;
    longint     lap;
    longint     total;
    longint     sgn;
    logic       last;
    site_word_t w;
    last = (cursor == NSITES - 1);
    if (cursor == 0) open_sweep();
    h = lattice[cursor];
    left = (cursor == 0) ? longint'(lattice[NSITES - 1]) : longint'(prev_old);
    right = last ? longint'(first_old) : longint'(lattice[cursor + 1]);
    if (cursor == 0) first_old = 32'(h);
    lap = right - 2 * h + left;
    sgn = (h > 0) ? 1 : ((h < 0) ? -1 : 0);
    total = h + rounded_scale(lap, 64'(dt_sweep) * 10, 32)
          + rounded_scale(longint'(noise), 64'(noise_gain), 12)
          - sgn * rounded_scale(longint'(force_h), 64'(dt_sweep), 32);
    if (total > 64'sd2147483647) total = 64'sd2147483647;
    if (total < -64'sd2147483648) total = -64'sd2147483648;
    prev_old = 32'(h);
    lattice[cursor] = 32'(total);
    w.site = cursor[SITE_OUT_W-1:0];
    w.height = 32'(total);
    w.dt = dt_sweep[STEP_W-1:0];
    w.last = last;
    updates_due.push_back(w);
    cursor = last ? 0 : cursor + 1;
  endtask

  always @(posedge clk) begin
    site_word_t w;
    if (!rst_n) begin
      for (int x = 0; x < NSITES; x++) lattice[x] = 32'((x * 65536 + 5) / 10);
      cursor = 0;
      dt_sweep = 0;
      noise_gain = 0;
      prev_old = 0;
      first_old = 0;
      gain_g = 0;
      force_h = 0;
      ttc = TEMP_RATIO_RESET;
      updates_due.delete();
      errors = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (updates_due.size() == 0) begin
          $display("%0t: unexpected word site %0d height %0d", $time, out_site_index,
                   out_new_height);
          errors++;
        end else begin
          w = updates_due.pop_front();
          if (out_site_index !== w.site) begin
            $display("%0t: site_index expected %0d actual %0d", $time, w.site,
                     out_site_index);
            errors++;
          end
          if (out_new_height !== w.height) begin
            $display("%0t: new_height expected %0d actual %0d", $time, w.height,
                     out_new_height);
            errors++;
          end
          if (out_step_size !== w.dt) begin
            $display("%0t: step_size expected %0d actual %0d", $time, w.dt, out_step_size);
            errors++;
          end
          if (out_last_of_sweep !== w.last) begin
            $display("%0t: last_of_sweep expected %0b actual %0b", $time, w.last,
                     out_last_of_sweep);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) predict_site(in_noise_sample);
      if (cfg_we) begin
        case (cfg_index)
          CFG_SHEAR_GAIN: gain_g = cfg_wdata;
          CFG_STEP_FORCE: force_h = cfg_wdata;
          CFG_TEMP_RATIO: ttc = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending = updates_due.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import lrls_pkg::*;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [NOISE_W-1:0]  in_noise_sample;
  logic                       out_valid;
  logic                       out_stall;
  logic [SITE_OUT_W-1:0]      out_site_index;
  logic signed [HEIGHT_W-1:0] out_new_height;
  logic [STEP_W-1:0]          out_step_size;
  logic                       out_last_of_sweep;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_wdata;
  int                         errors;
  int                         pending;
  bit                         quiet;
  bit                         hold_req;
  int                         hold_left;
  int                         idle_cycles;

  langevin_ring_lattice_step dut (.*);

  lrls_checker chk (.*);

  initial begin
    clk = 0;
    quiet = 0;
    hold_req = 0;
    hold_left = 0;
  end

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req) begin
      hold_req = 0;
      hold_left = 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 15);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 5000) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_word(logic signed [NOISE_W-1:0] noise);
    in_valid <= 1'b1;
    in_noise_sample <= noise;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (!quiet && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  function automatic logic [15:0] noise_pick();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(8192)) - 4096);
      2: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'($signed($urandom_range(400)) - 200);
    endcase
  endfunction

  task automatic run_phase(logic [31:0] g, logic [31:0] f, logic [31:0] t, int n);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    write_reg(CFG_SHEAR_GAIN, g);
    write_reg(CFG_STEP_FORCE, f);
    write_reg(CFG_TEMP_RATIO, t);
    repeat (n) send_word(noise_pick());
  endtask

  initial begin
    logic [15:0] edge_noise [7];
    rst_n = 0;
    in_valid = 0;
    in_noise_sample = 0;
    cfg_we = 0;
    cfg_index = CFG_SHEAR_GAIN;
    cfg_wdata = 0;
    edge_noise = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    foreach (edge_noise[k]) send_word(edge_noise[k]);
    repeat (18) send_word(noise_pick());
    quiet = 1;
    run_phase(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 70);
    quiet = 0;
    hold_req = 1;
    repeat (70) send_word(noise_pick());
    run_phase(32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 140);
    run_phase(32'h0001_0000, 32'h0010_0000, 32'h0004_0000, 140);
    run_phase(-32'sd1024, 32'($signed($urandom_range(65536)) - 32768), $urandom, 140);
    run_phase($urandom, $urandom, $urandom, 140);
    run_phase(32'd0, 32'hFFF0_0000, 32'hFFFF_FFFF, 100);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
